// File: sv/bbn_pkg.sv
// Shared types and constants for the mesh bounding box normalizer.
`timescale 1ns / 1ps

package bbn_pkg;

	// Coordinate format: signed fixed point with FRAC_W fraction bits.
	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int BOX_W   = 31;
	// Box extents and coordinate differences need one more bit than a coordinate.
	localparam int EXT_W   = COORD_W + 1;
	localparam int PROD_W  = 2 * EXT_W;
	localparam int SCALE_W = COORD_W;
	// Scale dividend is box_size shifted up by the fraction bits.
	localparam int DVD_W   = BOX_W + FRAC_W;
	// Queue depth between front and back; a power of two.
	localparam int Q_DEPTH = 2;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	// Default target size is 4.0.
	localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(4) << FRAC_W;

	typedef enum logic [1:0] {
		OP_CLEAR     = 2'd0,
		OP_MEASURE   = 2'd1,
		OP_TRANSFORM = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DRAIN,
		F_PREP,
		F_DIV
	} front_state_t;

	// One transform job handed from the front to the back.
	typedef struct packed {
		logic                      degen;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} job_t;

	// Offsets and scale latched by the front, used by the back.
	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] base_z;
		logic [SCALE_W-1:0]        scale;
	} xform_t;

endpackage

// File: sv/bbn_in_if.sv
// Vertex input channel: valid/ready handshake with the operation and vertex.
`timescale 1ns / 1ps

interface bbn_in_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         operation;
	logic signed [bbn_pkg::COORD_W-1:0] vert_x;
	logic signed [bbn_pkg::COORD_W-1:0] vert_y;
	logic signed [bbn_pkg::COORD_W-1:0] vert_z;

	modport source (output valid, operation, vert_x, vert_y, vert_z, input ready);
	modport sink (input valid, operation, vert_x, vert_y, vert_z, output ready);
endinterface

// File: sv/bbn_out_if.sv
// Result channel: valid/ready handshake with the normalized vertex.
`timescale 1ns / 1ps

interface bbn_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [bbn_pkg::COORD_W-1:0] norm_x;
	logic signed [bbn_pkg::COORD_W-1:0] norm_y;
	logic signed [bbn_pkg::COORD_W-1:0] norm_z;
	logic                               degenerate;

	modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// File: sv/bbn_div.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module bbn_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bbn_pkg::DVD_W-1:0]    dividend,
	input  logic [bbn_pkg::COORD_W-1:0]  divisor,
	output logic                         done,
	output logic [bbn_pkg::DVD_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(bbn_pkg::DVD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bbn_pkg::DVD_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [bbn_pkg::COORD_W-1:0]   rem_q;
	logic [bbn_pkg::COORD_W-1:0]   dvs_q;
	logic [bbn_pkg::DVD_W-1:0]     quo_q;

	logic [bbn_pkg::COORD_W:0]     trial;
	logic [bbn_pkg::COORD_W:0]     diff;
	logic                          fits;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[bbn_pkg::DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder and a shift register that turns dividend into quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[bbn_pkg::COORD_W-1:0] : trial[bbn_pkg::COORD_W-1:0];
			quo_q <= {quo_q[bbn_pkg::DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/bbn_fifo.sv
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module bbn_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bbn_pkg::job_t     push_job,
	input  logic              pop,
	output bbn_pkg::job_t     pop_job,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = $clog2(bbn_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(bbn_pkg::Q_DEPTH + 1);

	bbn_pkg::job_t      mem_q [bbn_pkg::Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// Pointers and fill level; the depth is a power of two so pointers wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	assign pop_job = mem_q[rd_ptr_q];
	assign full    = count_q == CNT_W'(bbn_pkg::Q_DEPTH);
	assign empty   = count_q == '0;

	// The front never pushes into a full queue and the back never pops an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

endmodule

// File: sv/bbn_front.sv
// Front end: accepts items, tracks the bounding box and latches offsets and scale.
`timescale 1ns / 1ps

module bbn_front (
	input  logic                        clk,
	input  logic                        arst_n,
	bbn_in_if.sink                      vtx,
	input  logic                        cfg_wr_en,
	input  logic [bbn_pkg::BOX_W-1:0]   cfg_wr_data,
	input  logic                        q_full,
	input  logic                        q_empty,
	input  logic                        back_idle,
	output logic                        push,
	output bbn_pkg::job_t               push_job,
	output bbn_pkg::xform_t             xform
);

	localparam int CW = bbn_pkg::COORD_W;
	localparam int EW = bbn_pkg::EXT_W;

	bbn_pkg::front_state_t   state_q;
	bbn_pkg::front_state_t   state_d;

	logic [bbn_pkg::BOX_W-1:0] box_size_q;
	logic signed [CW-1:0]      low_x_q, high_x_q, low_y_q, high_y_q, low_z_q, high_z_q;
	logic                      box_valid_q;
	logic                      scale_ready_q;
	bbn_pkg::job_t             hold_q;
	logic signed [EW-1:0]      ext_x_q, ext_y_q, ext_z_q;
	bbn_pkg::xform_t           xform_q;

	logic                      acc;
	logic                      is_clear, is_measure, is_xf;
	logic                      degen_now;
	logic                      need_prep;
	logic signed [EW-1:0]      big;
	logic                      div_start;
	logic                      div_done;
	logic [bbn_pkg::DVD_W-1:0] div_quo;
	logic [bbn_pkg::SCALE_W-1:0] scale_sat;

	// Item classification. A box is degenerate when nothing was measured since
	// the clear or when every axis has zero extent.
	always_comb begin
		acc        = vtx.valid && vtx.ready;
		is_clear   = acc && (vtx.operation == bbn_pkg::OP_CLEAR);
		is_measure = acc && (vtx.operation == bbn_pkg::OP_MEASURE);
		is_xf      = acc && (vtx.operation == bbn_pkg::OP_TRANSFORM);
		degen_now  = !box_valid_q ||
			((low_x_q == high_x_q) && (low_y_q == high_y_q) && (low_z_q == high_z_q));
		need_prep  = is_xf && !degen_now && !scale_ready_q;
	end

	// Largest extent; all extents are non-negative once the box holds a vertex.
	always_comb begin
		big = ext_x_q;
		if (ext_y_q > big) begin
			big = ext_y_q;
		end
		if (ext_z_q > big) begin
			big = ext_z_q;
		end
	end

	// Quotient saturates to the scale width.
	assign scale_sat = (|div_quo[bbn_pkg::DVD_W-1:bbn_pkg::SCALE_W]) ? '1 :
		div_quo[bbn_pkg::SCALE_W-1:0];

	bbn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({box_size_q, bbn_pkg::FRAC_W'(0)}),
		.divisor  (big[CW-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbn_pkg::F_IDLE: begin
				if (need_prep) begin
					state_d = bbn_pkg::F_DRAIN;
				end
			end
			bbn_pkg::F_DRAIN: begin
				if (q_empty && back_idle) begin
					state_d = bbn_pkg::F_PREP;
				end
			end
			bbn_pkg::F_PREP: begin
				state_d = bbn_pkg::F_DIV;
			end
			bbn_pkg::F_DIV: begin
				if (div_done) begin
					state_d = bbn_pkg::F_IDLE;
				end
			end
		endcase
	end

	// Outputs per state.
	always_comb begin
		vtx.ready = 1'b0;
		push      = 1'b0;
		push_job  = hold_q;
		div_start = 1'b0;
		unique case (state_q)
			bbn_pkg::F_IDLE: begin
				vtx.ready = !q_full;
				push      = is_xf && !need_prep;
				push_job  = '{degen: degen_now, x: vtx.vert_x, y: vtx.vert_y, z: vtx.vert_z};
			end
			bbn_pkg::F_DRAIN: begin
			end
			bbn_pkg::F_PREP: begin
				div_start = 1'b1;
			end
			bbn_pkg::F_DIV: begin
				push = div_done;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbn_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bounding box and readiness of the latched scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_size_q    <= bbn_pkg::BOX_RESET;
			low_x_q       <= bbn_pkg::COORD_MAX;
			low_y_q       <= bbn_pkg::COORD_MAX;
			low_z_q       <= bbn_pkg::COORD_MAX;
			high_x_q      <= bbn_pkg::COORD_MIN;
			high_y_q      <= bbn_pkg::COORD_MIN;
			high_z_q      <= bbn_pkg::COORD_MIN;
			box_valid_q   <= 1'b0;
			scale_ready_q <= 1'b0;
		end else begin
			if (is_clear) begin
				low_x_q       <= bbn_pkg::COORD_MAX;
				low_y_q       <= bbn_pkg::COORD_MAX;
				low_z_q       <= bbn_pkg::COORD_MAX;
				high_x_q      <= bbn_pkg::COORD_MIN;
				high_y_q      <= bbn_pkg::COORD_MIN;
				high_z_q      <= bbn_pkg::COORD_MIN;
				box_valid_q   <= 1'b0;
				scale_ready_q <= 1'b0;
			end else if (is_measure) begin
				if (vtx.vert_x < low_x_q)  low_x_q  <= vtx.vert_x;
				if (vtx.vert_x > high_x_q) high_x_q <= vtx.vert_x;
				if (vtx.vert_y < low_y_q)  low_y_q  <= vtx.vert_y;
				if (vtx.vert_y > high_y_q) high_y_q <= vtx.vert_y;
				if (vtx.vert_z < low_z_q)  low_z_q  <= vtx.vert_z;
				if (vtx.vert_z > high_z_q) high_z_q <= vtx.vert_z;
				box_valid_q   <= 1'b1;
				scale_ready_q <= 1'b0;
			end else if ((state_q == bbn_pkg::F_DIV) && div_done) begin
				scale_ready_q <= 1'b1;
			end
			if (cfg_wr_en) begin
				box_size_q    <= cfg_wr_data;
				scale_ready_q <= 1'b0;
			end
		end
	end

	// Held vertex and box extents. Extents are taken while the back drains,
	// when the box can no longer change.
	always_ff @(posedge clk) begin
		if (need_prep) begin
			hold_q <= '{degen: 1'b0, x: vtx.vert_x, y: vtx.vert_y, z: vtx.vert_z};
		end
		if (state_q == bbn_pkg::F_DRAIN) begin
			ext_x_q <= EW'(high_x_q) - EW'(low_x_q);
			ext_y_q <= EW'(high_y_q) - EW'(low_y_q);
			ext_z_q <= EW'(high_z_q) - EW'(low_z_q);
		end
	end

	// Offsets are latched while the divider starts; the scale when it finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xform_q <= '0;
		end else begin
			if (state_q == bbn_pkg::F_PREP) begin
				xform_q.center_x <= CW'(EW'(low_x_q) + (ext_x_q >>> 1));
				xform_q.center_y <= CW'(EW'(low_y_q) + (ext_y_q >>> 1));
				xform_q.base_z   <= low_z_q;
			end
			if ((state_q == bbn_pkg::F_DIV) && div_done) begin
				xform_q.scale <= scale_sat;
			end
		end
	end

	assign xform = xform_q;

	// New offsets are only computed once every earlier job has left the back.
	a_prep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbn_pkg::F_PREP) |-> (q_empty && back_idle))
		else $error("offsets prepared while jobs are in flight");
	a_scale_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!back_idle |=> $stable(xform_q))
		else $error("scale changed under a job in the back");
	a_div_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bbn_pkg::F_DIV) && push) |-> q_empty)
		else $error("held item pushed behind other jobs");

endmodule

// File: sv/bbn_back.sv
// Back end: subtract offset, multiply by scale, shift and saturate, output register.
`timescale 1ns / 1ps

module bbn_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  bbn_pkg::job_t      pop_job,
	input  bbn_pkg::xform_t    xform,
	output logic               pop,
	output logic               back_idle,
	bbn_out_if.source          nrm
);

	localparam int CW = bbn_pkg::COORD_W;
	localparam int EW = bbn_pkg::EXT_W;
	localparam int PW = bbn_pkg::PROD_W;

	logic                  en;
	logic                  v_s1, v_s2, v_s3;
	logic                  degen_s1, degen_s2, degen_s3;
	logic signed [EW-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0]  px_s2, py_s2, pz_s2;
	logic signed [CW-1:0]  nx_s3, ny_s3, nz_s3;
	logic signed [EW-1:0]  scale_s;

	// Floor shift by the fraction bits, then clamp to the coordinate range.
	function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] sh;
		sh = p >>> bbn_pkg::FRAC_W;
		if ((&sh[PW-1:CW-1]) || !(|sh[PW-1:CW-1])) begin
			return sh[CW-1:0];
		end
		return sh[PW-1] ? bbn_pkg::COORD_MIN : bbn_pkg::COORD_MAX;
	endfunction

	// The whole pipe advances when the output register is free or being taken.
	assign en        = !v_s3 || nrm.ready;
	assign pop       = en && !q_empty;
	assign back_idle = !v_s1 && !v_s2 && !v_s3;
	assign scale_s   = $signed({1'b0, xform.scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: difference to the offset.
	always_ff @(posedge clk) begin
		if (en) begin
			degen_s1 <= pop_job.degen;
			dx_s1    <= EW'($signed(pop_job.x)) - EW'(xform.center_x);
			dy_s1    <= EW'($signed(pop_job.y)) - EW'(xform.center_y);
			dz_s1    <= EW'($signed(pop_job.z)) - EW'(xform.base_z);
		end
	end

	// Stage 2: exact product with the scale, one multiplier per axis.
	always_ff @(posedge clk) begin
		if (en) begin
			degen_s2 <= degen_s1;
			px_s2    <= PW'(dx_s1) * PW'(scale_s);
			py_s2    <= PW'(dy_s1) * PW'(scale_s);
			pz_s2    <= PW'(dz_s1) * PW'(scale_s);
		end
	end

	// Stage 3: result register; a degenerate box gives zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			degen_s3 <= degen_s2;
			nx_s3    <= degen_s2 ? '0 : sat_coord(px_s2);
			ny_s3    <= degen_s2 ? '0 : sat_coord(py_s2);
			nz_s3    <= degen_s2 ? '0 : sat_coord(pz_s2);
		end
	end

	assign nrm.valid      = v_s3;
	assign nrm.norm_x     = nx_s3;
	assign nrm.norm_y     = ny_s3;
	assign nrm.norm_z     = nz_s3;
	assign nrm.degenerate = degen_s3;

	// A degenerate result carries all-zero coordinates.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && degen_s3) |-> ((nx_s3 == '0) && (ny_s3 == '0) && (nz_s3 == '0)))
		else $error("degenerate result with nonzero coordinates");

endmodule

// File: sv/mesh_bounding_box_normalizer_core.sv
// Top level of the mesh bounding box normalizer.
//
// Clear and measure items are taken at one per cycle while the queue has room
// and no scale is pending, and give no result; transform items give one result
// each, at one per cycle unless the output stalls, via the two-entry job queue
// and back pipeline. The first transform item after a clear, a measure or a
// box_size write (unless the box is degenerate) waits for all earlier jobs to
// leave the back pipeline while the extents are registered, then latches the
// centers and runs the radix-2 restoring divider that forms box_size / largest
// extent one quotient bit per cycle. Every later transform item of the pass runs
// at full rate. box_size may be written only while no item is in flight.
`timescale 1ns / 1ps

module mesh_bounding_box_normalizer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bbn_pkg::BOX_W-1:0]   cfg_wr_data,
	bbn_in_if.sink                      vtx,
	bbn_out_if.source                   nrm
);

	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	logic               back_idle;
	bbn_pkg::job_t      push_job;
	bbn_pkg::job_t      pop_job;
	bbn_pkg::xform_t    xform;

	bbn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.vtx         (vtx),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.q_empty     (q_empty),
		.back_idle   (back_idle),
		.push        (push),
		.push_job    (push_job),
		.xform       (xform)
	);

	bbn_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	bbn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop_job   (pop_job),
		.xform     (xform),
		.pop       (pop),
		.back_idle (back_idle),
		.nrm       (nrm)
	);

endmodule

// File: bench/tb_mesh_bounding_box_normalizer_core.sv
// Self-checking testbench for the mesh bounding box normalizer core.
`timescale 1ns / 1ps

module tb_mesh_bounding_box_normalizer_core;

	// The operation code that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles to let pass after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 365;

	typedef struct packed {
		logic [1:0]                         op;
		logic signed [bbn_pkg::COORD_W-1:0] x;
		logic signed [bbn_pkg::COORD_W-1:0] y;
		logic signed [bbn_pkg::COORD_W-1:0] z;
	} vertex_item_t;

	typedef struct packed {
		logic signed [bbn_pkg::COORD_W-1:0] x;
		logic signed [bbn_pkg::COORD_W-1:0] y;
		logic signed [bbn_pkg::COORD_W-1:0] z;
		logic                               degen;
	} norm_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [bbn_pkg::BOX_W-1:0] cfg_wr_data;

	bbn_in_if  vtx_ch ();
	bbn_out_if nrm_ch ();

	mesh_bounding_box_normalizer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.vtx         (vtx_ch),
		.nrm         (nrm_ch)
	);

	vertex_item_t pending_items[$];
	norm_result_t expected_norms[$];
	vertex_item_t cur_item;
	bit vtx_taken;
	bit calm;
	int send_gap;
	int sink_gap;
	int fail_count;
	int queued_count;

	// Predictor state: bounding box, latched offsets and scale, target size.
	logic [bbn_pkg::BOX_W-1:0]          box_size;
	logic signed [bbn_pkg::COORD_W-1:0] box_lo[3];
	logic signed [bbn_pkg::COORD_W-1:0] box_hi[3];
	logic signed [bbn_pkg::COORD_W-1:0] offset[3];
	logic [bbn_pkg::SCALE_W-1:0]        scale;
	bit                                 offsets_latched;

	always #5 clk = ~clk;

	function automatic void clear_box();
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = bbn_pkg::COORD_MAX;
			box_hi[i] = bbn_pkg::COORD_MIN;
		end
		offsets_latched = 0;
	endfunction

	// One axis: (coord - offset) * scale, floored by the fraction shift, saturated.
	function automatic logic signed [bbn_pkg::COORD_W-1:0] scale_axis(
			input logic signed [bbn_pkg::COORD_W-1:0] c,
			input logic signed [bbn_pkg::COORD_W-1:0] off);
		logic signed [79:0] diff;
		logic signed [79:0] prod;
		diff = 80'(c) - 80'(off);
		prod = diff * $signed({48'd0, scale});
		prod = prod >>> bbn_pkg::FRAC_W;
		if (prod > 80'(bbn_pkg::COORD_MAX))
			return bbn_pkg::COORD_MAX;
		if (prod < 80'(bbn_pkg::COORD_MIN))
			return bbn_pkg::COORD_MIN;
		return prod[bbn_pkg::COORD_W-1:0];
	endfunction

	// Applies one item to the predictor; returns 1 when the item gives a result.
	function automatic bit normalize_vertex(input vertex_item_t v, output norm_result_t r);
		logic signed [bbn_pkg::COORD_W-1:0] c[3];
		longint ext[3];
		longint widest;
		longint unsigned dividend;
		longint unsigned quot;
		c[0] = v.x;
		c[1] = v.y;
		c[2] = v.z;
		r = '0;
		case (v.op)
			bbn_pkg::OP_CLEAR: begin
				clear_box();
				return 0;
			end
			bbn_pkg::OP_MEASURE: begin
				for (int i = 0; i < 3; i++) begin
					if (c[i] > box_hi[i])
						box_hi[i] = c[i];
					if (c[i] < box_lo[i])
						box_lo[i] = c[i];
				end
				offsets_latched = 0;
				return 0;
			end
			bbn_pkg::OP_TRANSFORM: begin
				for (int i = 0; i < 3; i++)
					ext[i] = longint'(box_hi[i]) - longint'(box_lo[i]);
				widest = ext[0];
				if (ext[1] > widest)
					widest = ext[1];
				if (ext[2] > widest)
					widest = ext[2];
				// An empty or flat box gives zeros with the degenerate flag.
				if (widest <= 0) begin
					r.degen = 1'b1;
					return 1;
				end
				if (!offsets_latched) begin
					dividend = longint'(box_size) << bbn_pkg::FRAC_W;
					quot = dividend / longint'(widest);
					scale = (quot > 64'hFFFF_FFFF) ? '1 : quot[bbn_pkg::SCALE_W-1:0];
					offset[0] = 32'(longint'(box_lo[0]) + ext[0] / 2);
					offset[1] = 32'(longint'(box_lo[1]) + ext[1] / 2);
					offset[2] = box_lo[2];
					offsets_latched = 1;
				end
				r.x = scale_axis(c[0], offset[0]);
				r.y = scale_axis(c[1], offset[1]);
				r.z = scale_axis(c[2], offset[2]);
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic push_item(input logic [1:0] op,
			input logic signed [bbn_pkg::COORD_W-1:0] x,
			input logic signed [bbn_pkg::COORD_W-1:0] y,
			input logic signed [bbn_pkg::COORD_W-1:0] z);
		pending_items.push_back('{op, x, y, z});
		if (op != OP_UNUSED)
			queued_count++;
	endtask

	// A coordinate near mid within 2^span_log, with extremes and full-range values mixed in.
	function automatic logic signed [bbn_pkg::COORD_W-1:0] pick_coord(input longint mid,
			input int span_log);
		longint span;
		longint val;
		case ($urandom_range(0, 15))
			0: return bbn_pkg::COORD_MAX;
			1: return bbn_pkg::COORD_MIN;
			2: return '0;
			3, 4: return $urandom;
			default: begin
				span = longint'(1) << span_log;
				val = mid - span / 2 + longint'($urandom) % span;
				if (val > longint'(bbn_pkg::COORD_MAX))
					val = longint'(bbn_pkg::COORD_MAX);
				if (val < longint'(bbn_pkg::COORD_MIN))
					val = longint'(bbn_pkg::COORD_MIN);
				return 32'(val);
			end
		endcase
	endfunction

	// One measure pass followed by its transform pass, with some noise mixed in.
	task automatic queue_pass();
		longint mid[3];
		int span_log;
		int n_meas;
		int n_xform;
		bit flat;
		logic signed [bbn_pkg::COORD_W-1:0] v[3];
		for (int i = 0; i < 3; i++)
			mid[i] = longint'($signed($urandom));
		span_log = $urandom_range(0, 32);
		n_meas = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
		n_xform = $urandom_range(1, 10);
		flat = ($urandom_range(0, 9) == 0);
		// Now and then the box keeps growing from the previous pass.
		if ($urandom_range(0, 7) != 0)
			push_item(bbn_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
		for (int i = 0; i < 3; i++)
			v[i] = pick_coord(mid[i], span_log);
		for (int m = 0; m < n_meas; m++) begin
			if (!flat)
				for (int i = 0; i < 3; i++)
					v[i] = pick_coord(mid[i], span_log);
			push_item(bbn_pkg::OP_MEASURE, v[0], v[1], v[2]);
		end
		for (int t = 0; t < n_xform; t++) begin
			case ($urandom_range(0, 19))
				0: push_item(bbn_pkg::OP_MEASURE, pick_coord(mid[0], span_log),
					pick_coord(mid[1], span_log), pick_coord(mid[2], span_log));
				1: push_item(OP_UNUSED, $urandom, $urandom, $urandom);
				default: ;
			endcase
			push_item(bbn_pkg::OP_TRANSFORM, pick_coord(mid[0], span_log + 1),
				pick_coord(mid[1], span_log + 1), pick_coord(mid[2], span_log + 1));
		end
	endtask

	task automatic queue_directed();
		// Transform with nothing measured, then an ignored code.
		push_item(bbn_pkg::OP_TRANSFORM, 32'sd1, 32'sd2, 32'sd3);
		push_item(OP_UNUSED, bbn_pkg::COORD_MAX, bbn_pkg::COORD_MIN, -32'sd1);
		// A single vertex leaves the box flat.
		push_item(bbn_pkg::OP_MEASURE, 32'sh0005_0000, -32'sh0003_0000, 32'sd7);
		push_item(bbn_pkg::OP_TRANSFORM, 32'sd0, 32'sd0, 32'sd0);
		// Full-range box.
		push_item(bbn_pkg::OP_MEASURE, bbn_pkg::COORD_MIN, bbn_pkg::COORD_MIN,
			bbn_pkg::COORD_MIN);
		push_item(bbn_pkg::OP_MEASURE, bbn_pkg::COORD_MAX, bbn_pkg::COORD_MAX,
			bbn_pkg::COORD_MAX);
		push_item(bbn_pkg::OP_TRANSFORM, bbn_pkg::COORD_MAX, bbn_pkg::COORD_MIN, 32'sd0);
		push_item(bbn_pkg::OP_TRANSFORM, bbn_pkg::COORD_MIN, bbn_pkg::COORD_MAX,
			bbn_pkg::COORD_MAX);
		push_item(bbn_pkg::OP_TRANSFORM, 32'sd0, -32'sd1, bbn_pkg::COORD_MIN);
		// A measure after transforms forces fresh offsets.
		push_item(bbn_pkg::OP_MEASURE, 32'sd0, 32'sd0, 32'sd0);
		push_item(bbn_pkg::OP_TRANSFORM, 32'sh0001_0000, -32'sh0001_0000, 32'sd1);
		// Box one LSB wide: the scale saturates and so do the products.
		push_item(bbn_pkg::OP_CLEAR, 32'sd0, 32'sd0, 32'sd0);
		push_item(bbn_pkg::OP_MEASURE, 32'sd0, 32'sd0, 32'sd0);
		push_item(bbn_pkg::OP_MEASURE, 32'sd1, 32'sd0, 32'sd0);
		push_item(bbn_pkg::OP_TRANSFORM, bbn_pkg::COORD_MAX, bbn_pkg::COORD_MIN,
			bbn_pkg::COORD_MAX);
		push_item(bbn_pkg::OP_TRANSFORM, 32'sd1, 32'sd1, 32'sd1);
		push_item(bbn_pkg::OP_TRANSFORM, -32'sd1, -32'sd1, -32'sd1);
		push_item(OP_UNUSED, 32'sd0, 32'sd0, 32'sd0);
		// Cleared box again gives the degenerate result.
		push_item(bbn_pkg::OP_CLEAR, -32'sd1, -32'sd1, -32'sd1);
		push_item(bbn_pkg::OP_TRANSFORM, 32'sd0, 32'sd0, 32'sd0);
		// A plain 2.0 wide box: scale of exactly two.
		push_item(bbn_pkg::OP_MEASURE, -32'sh0001_0000, 32'sd0, 32'sd0);
		push_item(bbn_pkg::OP_MEASURE, 32'sh0001_0000, 32'sd0, 32'sh0002_0000);
		push_item(bbn_pkg::OP_TRANSFORM, 32'sh0000_8000, 32'sh0001_0000, -32'sh0001_0000);
	endtask

	// Waits until every item is taken and every result has come, plus a margin.
	task automatic wait_quiet();
		while (pending_items.size() != 0 || vtx_ch.valid || expected_norms.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_box_size(input logic [bbn_pkg::BOX_W-1:0] val);
		wait_quiet();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		box_size = val;
		offsets_latched = 0;
	endtask

	// Vertex driver: presents the next pending item once the current one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			vtx_ch.valid <= 1'b0;
		end else if (!vtx_ch.valid || vtx_taken) begin
			vtx_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				vtx_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				vtx_ch.operation <= cur_item.op;
				vtx_ch.vert_x <= cur_item.x;
				vtx_ch.vert_y <= cur_item.y;
				vtx_ch.vert_z <= cur_item.z;
				vtx_ch.valid <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 11);
			end else begin
				vtx_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink with random stall bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			nrm_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			nrm_ch.ready <= 1'b0;
		end else begin
			nrm_ch.ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) == 0)
				sink_gap = $urandom_range(1, 11);
		end
	end

	// Each taken item updates the predictor and may queue an expected result.
	always @(posedge clk) begin
		norm_result_t res;
		if (arst_n && vtx_ch.valid && vtx_ch.ready) begin
			if (normalize_vertex(cur_item, res))
				expected_norms.push_back(res);
			vtx_taken = 1'b1;
		end
	end

	// Result monitor: compares each result with the oldest expected one.
	always @(posedge clk) begin
		norm_result_t want;
		norm_result_t got;
		if (arst_n && nrm_ch.valid && nrm_ch.ready) begin
			got = '{nrm_ch.norm_x, nrm_ch.norm_y, nrm_ch.norm_z, nrm_ch.degenerate};
			if (expected_norms.size() == 0) begin
				flag_error($sformatf("unexpected result x=%0d y=%0d z=%0d degenerate=%0b",
					got.x, got.y, got.z, got.degen));
			end else begin
				want = expected_norms.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z
						|| got.degen !== want.degen)
					flag_error($sformatf(
						"mismatch: expected x=%0d y=%0d z=%0d deg=%0b, got x=%0d y=%0d z=%0d deg=%0b",
						want.x, want.y, want.z, want.degen,
						got.x, got.y, got.z, got.degen));
			end
		end
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("tb_mesh_bounding_box_normalizer_core failed");
		$finish;
	end

	// Main sequence: reset, directed items, then random phases over several box sizes.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		vtx_ch.valid = 1'b0;
		vtx_ch.operation = '0;
		vtx_ch.vert_x = '0;
		vtx_ch.vert_y = '0;
		vtx_ch.vert_z = '0;
		nrm_ch.ready = 1'b0;
		vtx_taken = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		sink_gap = 0;
		fail_count = 0;
		queued_count = 0;
		box_size = bbn_pkg::BOX_RESET;
		scale = '0;
		for (int i = 0; i < 3; i++)
			offset[i] = '0;
		clear_box();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_directed();

		// Smallest and largest targets, then random ones.
		write_box_size(31'd1);
		queued_count = 0;
		while (queued_count < PHASE_ITEMS)
			queue_pass();
		write_box_size({bbn_pkg::BOX_W{1'b1}});
		queued_count = 0;
		while (queued_count < PHASE_ITEMS)
			queue_pass();
		write_box_size(bbn_pkg::BOX_W'($urandom_range(1, 32'h7FFF_FFFF)));
		queued_count = 0;
		while (queued_count < PHASE_ITEMS)
			queue_pass();
		write_box_size(bbn_pkg::BOX_W'(1) << $urandom_range(0, bbn_pkg::BOX_W - 1));
		queued_count = 0;
		while (queued_count < PHASE_ITEMS)
			queue_pass();

		// Last phase at the default size, streaming with no idle cycles.
		write_box_size(bbn_pkg::BOX_RESET);
		calm = 1'b1;
		queued_count = 0;
		while (queued_count < PHASE_ITEMS)
			queue_pass();

		wait_quiet();
		if (fail_count == 0)
			$display("tb_mesh_bounding_box_normalizer_core passed");
		else
			$display("tb_mesh_bounding_box_normalizer_core failed");
		$finish;
	end

endmodule
